>>> rtl/core/lkvc_pkg.sv
package lkvc_pkg;

   // operation codes
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   // reply value on a get miss, and on every put
   localparam logic signed [31:0] READ_MISS = -32'sd1;
   localparam logic signed [31:0] PUT_REPLY = 32'sd0;

   localparam logic [4:0] CAPACITY_RESET = 5'd16;

   typedef struct packed {
      logic               command;
      logic signed [31:0] key;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               found;
      logic signed [31:0] read_value;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;          // capture request, start search sweep
      logic search;        // search sweep in progress
      logic update_begin;  // commit valid bits, start rank sweep
      logic update;        // rank sweep in progress
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last;          // data of the final entry is in this cycle
      logic hit;
      logic is_put;
   } status_type;

endpackage

>>> rtl/core/lru_key_value_cache_top.sv
// channel  | ports                              | transfer when
// ---------+------------------------------------+---------------------------------
// request  | start, busy, req_data              | start high and busy low
// response | rsp_strobe, rsp_data               | rsp_strobe high (one cycle)
// csr      | csr_write_enable, csr_write_data   | csr_write_enable high
//
// N = MAX_ENTRIES. Each operation sweeps the entry RAM one entry a cycle: a
// search sweep, then for a hit or a put a rank sweep that writes back ranks.
// The strobe follows the search sweep for a get miss and the rank sweep otherwise;
// busy drops the cycle after the strobe, so one request is in flight at a time.
// Reset (synchronous) empties the store and sets capacity to 16 at once.
// Responses cannot be stalled; a csr write is only legal while busy is low.
module lru_key_value_cache_top #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lkvc_pkg::req_type req_data,
   output logic             rsp_strobe,
   output lkvc_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic [4:0]       csr_write_data
);

   import lkvc_pkg::*;

   cmd_type    cmd;
   status_type status;

   lkvc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   lkvc_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request transfer did not raise busy");

   a_reply_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!rsp_strobe && !busy))
      else $error("response not followed by idle");

   a_sweep_end_once: assert property (@(posedge clock) disable iff (reset)
      status.last |=> !status.last)
      else $error("sweep end seen twice in a row");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.update_begin |-> (!cmd.search && !cmd.update && !status.last))
      else $error("rank sweep started while a sweep is still running");

endmodule

>>> rtl/core/lkvc_ram.sv
module lkvc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/lkvc_ctrl.sv
module lkvc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  lkvc_pkg::status_type status,
   output logic                busy,
   output logic                rsp_strobe,
   output lkvc_pkg::cmd_type    cmd
);

   import lkvc_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SEARCH = 5'b00010,
      ST_PREP   = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_REPLY  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
            if (status.last) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            // a get miss leaves the store untouched
            if (status.is_put || status.hit) begin
               cmd.update_begin = 1'b1;
               state_in         = ST_UPDATE;
            end else begin
               state_in = ST_REPLY;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (status.last) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_REPLY);

endmodule

>>> rtl/core/lkvc_datapath.sv
module lkvc_datapath #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lkvc_pkg::req_type     req_data,
   input  lkvc_pkg::cmd_type     cmd,
   output lkvc_pkg::status_type  status,
   output lkvc_pkg::rsp_type     rsp_data,
   input  logic                 csr_write_enable,
   input  logic [4:0]           csr_write_data
);

   import lkvc_pkg::*;

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int RW = IW;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int EW = (CW > 5) ? CW : 5;
   localparam int WW = RW + 64;
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);

   logic [4:0]             cap_ff, cap_in;
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [CW-1:0]          count_ff, count_in;
   req_type                req_ff, req_in;

   logic                   issuing_ff, issuing_in;
   logic [IW-1:0]          idx_ff, idx_in;
   logic                   d_vld_ff, d_vld_in;
   logic [IW-1:0]          d_idx_ff, d_idx_in;

   logic                   hit_ff, hit_in;
   logic [IW-1:0]          hit_idx_ff, hit_idx_in;
   logic [RW-1:0]          hit_rank_ff, hit_rank_in;
   logic [31:0]            hit_value_ff, hit_value_in;
   logic                   victim_ff, victim_in;
   logic [IW-1:0]          victim_idx_ff, victim_idx_in;
   logic                   free_ff, free_in;
   logic [IW-1:0]          free_idx_ff, free_idx_in;
   logic                   insert_ff, insert_in;
   logic [IW-1:0]          target_ff, target_in;

   logic                   wr_en;
   logic [WW-1:0]          wr_data;
   logic [WW-1:0]          rd_word;
   logic [RW-1:0]          rd_rank;
   logic [31:0]            rd_key;
   logic [31:0]            rd_value;
   logic                   entry_vld;
   logic [EW-1:0]          limit;
   logic [RW-1:0]          oldest;
   logic                   insert_now;
   logic                   evict_now;

   // word layout: rank | key | value
   assign rd_rank   = rd_word[WW-1:64];
   assign rd_key    = rd_word[63:32];
   assign rd_value  = rd_word[31:0];
   assign entry_vld = valid_ff[d_idx_ff];
   assign oldest    = RW'(count_ff - CW'(1));

   // capacity zero acts as one, above the store size it saturates
   always_comb begin
      limit = EW'(cap_ff);
      if (limit == '0) begin
         limit = EW'(1);
      end
      if (limit > EW'(MAX_ENTRIES)) begin
         limit = EW'(MAX_ENTRIES);
      end
   end

   assign insert_now = (req_ff.command == CMD_PUT) && !hit_ff;
   assign evict_now  = insert_now && (count_ff != '0) && (EW'(count_ff) >= limit);

   always_comb begin
      cap_in        = cap_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      req_in        = req_ff;
      issuing_in    = issuing_ff;
      idx_in        = idx_ff;
      d_vld_in      = issuing_ff;
      d_idx_in      = idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_rank_in   = hit_rank_ff;
      hit_value_in  = hit_value_ff;
      victim_in     = victim_ff;
      victim_idx_in = victim_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      insert_in     = insert_ff;
      target_in     = target_ff;
      wr_en         = 1'b0;
      wr_data       = rd_word;

      // sweep address
      if (cmd.load || cmd.update_begin) begin
         issuing_in = 1'b1;
         idx_in     = '0;
      end else if (issuing_ff) begin
         if (idx_ff == LAST_IDX) begin
            issuing_in = 1'b0;
         end else begin
            idx_in = idx_ff + IW'(1);
         end
      end

      if (cmd.load) begin
         req_in    = req_data;
         hit_in    = 1'b0;
         victim_in = 1'b0;
         free_in   = 1'b0;
      end

      if (cmd.search && d_vld_ff) begin
         if (entry_vld && (rd_key == $unsigned(req_ff.key))) begin
            hit_in       = 1'b1;
            hit_idx_in   = d_idx_ff;
            hit_rank_in  = rd_rank;
            hit_value_in = rd_value;
         end
         if (entry_vld && !victim_ff && (rd_rank >= oldest)) begin
            victim_in     = 1'b1;
            victim_idx_in = d_idx_ff;
         end
         if (!entry_vld && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = d_idx_ff;
         end
      end

      if (cmd.update_begin) begin
         insert_in = insert_now;
         if (hit_ff) begin
            target_in = hit_idx_ff;
         end else if (evict_now && (!free_ff || (victim_idx_ff < free_idx_ff))) begin
            target_in = victim_idx_ff;
         end else begin
            target_in = free_idx_ff;
         end
         if (evict_now) begin
            valid_in[victim_idx_ff] = 1'b0;
         end
         if (insert_now) begin
            valid_in[target_in] = 1'b1;
            if (!evict_now) begin
               count_in = count_ff + CW'(1);
            end
         end
      end

      if (cmd.update && d_vld_ff) begin
         if (d_idx_ff == target_ff) begin
            wr_en = 1'b1;
            if (insert_ff) begin
               wr_data = {RW'(0), req_ff.key, req_ff.value};
            end else if (req_ff.command == CMD_PUT) begin
               wr_data = {RW'(0), rd_key, req_ff.value};
            end else begin
               wr_data = {RW'(0), rd_key, rd_value};
            end
         end else if (entry_vld && (insert_ff || (rd_rank < hit_rank_ff))) begin
            wr_en   = 1'b1;
            wr_data = {rd_rank + RW'(1), rd_key, rd_value};
         end
      end

      // capacity write empties the store
      if (csr_write_enable) begin
         cap_in   = csr_write_data;
         valid_in = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= CAPACITY_RESET;
         valid_ff   <= '0;
         count_ff   <= '0;
         issuing_ff <= 1'b0;
         idx_ff     <= '0;
         d_vld_ff   <= 1'b0;
         hit_ff     <= 1'b0;
         victim_ff  <= 1'b0;
         free_ff    <= 1'b0;
         insert_ff  <= 1'b0;
      end else begin
         cap_ff     <= cap_in;
         valid_ff   <= valid_in;
         count_ff   <= count_in;
         issuing_ff <= issuing_in;
         idx_ff     <= idx_in;
         d_vld_ff   <= d_vld_in;
         hit_ff     <= hit_in;
         victim_ff  <= victim_in;
         free_ff    <= free_in;
         insert_ff  <= insert_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      d_idx_ff      <= d_idx_in;
      hit_idx_ff    <= hit_idx_in;
      hit_rank_ff   <= hit_rank_in;
      hit_value_ff  <= hit_value_in;
      victim_idx_ff <= victim_idx_in;
      free_idx_ff   <= free_idx_in;
      target_ff     <= target_in;
   end

   lkvc_ram #(
      .WIDTH (WW),
      .DEPTH (MAX_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (d_idx_ff),
      .wr_data (wr_data),
      .rd_en   (issuing_ff),
      .rd_addr (idx_ff),
      .rd_data (rd_word)
   );

   assign status.last   = d_vld_ff && (d_idx_ff == LAST_IDX);
   assign status.hit    = hit_ff;
   assign status.is_put = (req_ff.command == CMD_PUT);

   always_comb begin
      rsp_data.found = hit_ff;
      if (req_ff.command == CMD_PUT) begin
         rsp_data.read_value = PUT_REPLY;
      end else if (hit_ff) begin
         rsp_data.read_value = $signed(hit_value_ff);
      end else begin
         rsp_data.read_value = READ_MISS;
      end
   end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
   import lkvc_pkg::*;

   localparam int ENTRIES       = 16;
   localparam int PHASES        = 9;
   localparam int PHASE_ITEMS   = 150;
   localparam int CYCLE_LIMIT   = 600_000;
   localparam int DRAIN_CYCLES  = 2 * ENTRIES + 8;

   typedef enum logic [1:0] {
      ROW_CHECKED,    // reply typed into the table
      ROW_PREDICTED,  // reply taken from the LRU model
      ROW_CSR         // capacity write, value[4:0] is the new capacity
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic         command;
      logic [31:0]  key;
      logic [31:0]  value;
      logic         found;
      logic [31:0]  read_value;
   } step_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_strobe;
   rsp_type    rsp_data;
   logic       csr_write_enable = 1'b0;
   logic [4:0] csr_write_data = '0;

   lru_key_value_cache_top #(
      .MAX_ENTRIES(ENTRIES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // LRU model state
   logic        slot_valid [ENTRIES];
   logic [31:0] slot_key   [ENTRIES];
   logic [31:0] slot_value [ENTRIES];
   int unsigned slot_rank  [ENTRIES];
   int unsigned live_count;
   logic [4:0]  capacity_reg = CAPACITY_RESET;

   rsp_type      pending_replies [$];
   rsp_type      want_reply;
   logic [31:0]  key_pool [$];
   step_row_type steps [$];
   int           mismatch_count = 0;
   int           reply_count = 0;
   int unsigned  cycle_count = 0;
   bit           no_idle = 1'b0;

   function automatic void clear_store();
      for (int i = 0; i < ENTRIES; i++) begin
         slot_valid[i] = 1'b0;
         slot_rank[i]  = 0;
      end
      live_count = 0;
   endfunction

   // make slot s most recent; everything younger ages by one
   function automatic void promote(int s);
      int unsigned r;
      r = slot_rank[s];
      for (int i = 0; i < ENTRIES; i++)
         if (slot_valid[i] && slot_rank[i] < r) slot_rank[i]++;
      slot_rank[s] = 0;
   endfunction

   function automatic rsp_type lru_access(input req_type item);
      rsp_type     reply;
      int          hit_slot;
      int unsigned limit;
      bit          placed;
      hit_slot = -1;
      placed   = 1'b0;
      for (int i = 0; i < ENTRIES; i++)
         if (slot_valid[i] && slot_key[i] == item.key) hit_slot = i;
      if (item.command == CMD_GET) begin
         if (hit_slot >= 0) begin
            promote(hit_slot);
            reply.found      = 1'b1;
            reply.read_value = slot_value[hit_slot];
         end else begin
            reply.found      = 1'b0;
            reply.read_value = READ_MISS;
         end
         return reply;
      end
      reply.read_value = PUT_REPLY;
      if (hit_slot >= 0) begin
         slot_value[hit_slot] = item.value;
         promote(hit_slot);
         reply.found = 1'b1;
         return reply;
      end
      reply.found = 1'b0;
      limit = (capacity_reg == 0) ? 1 : (capacity_reg > ENTRIES) ? ENTRIES : capacity_reg;
      if (live_count >= limit && live_count > 0) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (!placed && slot_valid[i] && slot_rank[i] >= live_count - 1) begin
               slot_valid[i] = 1'b0;
               live_count--;
               placed = 1'b1;
            end
         end
      end
      placed = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (!placed && !slot_valid[i]) begin
            for (int j = 0; j < ENTRIES; j++)
               if (slot_valid[j]) slot_rank[j]++;
            slot_valid[i] = 1'b1;
            slot_key[i]   = item.key;
            slot_value[i] = item.value;
            slot_rank[i]  = 0;
            live_count++;
            placed = 1'b1;
         end
      end
      return reply;
   endfunction

   function automatic step_row_type row(input row_kind_type kind, input logic command,
                                        input logic [31:0] key, input logic [31:0] value,
                                        input logic found = 1'b0,
                                        input logic [31:0] read_value = '0);
      step_row_type r;
      r.kind       = kind;
      r.command    = command;
      r.key        = key;
      r.value      = value;
      r.found      = found;
      r.read_value = read_value;
      return r;
   endfunction

   function automatic void add_step(input step_row_type r);
      steps.insert(steps.size(), r);
   endfunction

   function automatic logic [31:0] edge_word();
      case ($urandom_range(3, 0))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic int idle_gap();
      int r;
      r = $urandom_range(99, 0);
      if (no_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(4, 1);
      return $urandom_range(60, 10);
   endfunction

   function automatic req_type random_request();
      req_type item;
      int      r;
      item.command = ($urandom_range(99, 0) < 45) ? CMD_PUT : CMD_GET;
      r = $urandom_range(99, 0);
      if (r < 80)      item.key = key_pool[$urandom_range(key_pool.size() - 1, 0)];
      else if (r < 92) item.key = $urandom;
      else             item.key = edge_word();
      item.value = ($urandom_range(7, 0) == 0) ? edge_word() : $urandom;
      return item;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("[%0t] reply %0d: %s got %h want %h", $time, reply_count, what, got, want);
   endtask

   // request transfer: hold start until taken with busy low
   task automatic issue(input req_type item, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
   endtask

   task automatic write_capacity(input logic [4:0] cap);
      start <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      capacity_reg = cap;
      clear_store();
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         reply_count++;
         if (pending_replies.size() == 0) begin
            report_mismatch("unexpected reply", {31'b0, rsp_data.found}, 'x);
         end else begin
            want_reply = pending_replies.pop_front();
            if (rsp_data.found !== want_reply.found)
               report_mismatch("found", {31'b0, rsp_data.found}, {31'b0, want_reply.found});
            if (rsp_data.read_value !== want_reply.read_value)
               report_mismatch("read_value", rsp_data.read_value, want_reply.read_value);
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      req_type    item;
      rsp_type    reply;
      logic [4:0] cap;
      int         eff;
      int         pool_size;

      clear_store();

      add_step(row(ROW_CHECKED, CMD_GET, 32'h0000_0000, 32'h0, 1'b0, READ_MISS));
      add_step(row(ROW_CHECKED, CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, PUT_REPLY));
      add_step(row(ROW_CHECKED, CMD_GET, 32'h7FFF_FFFF, 32'h0, 1'b1, 32'h8000_0000));
      add_step(row(ROW_CHECKED, CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, PUT_REPLY));
      add_step(row(ROW_CHECKED, CMD_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, PUT_REPLY));
      add_step(row(ROW_CHECKED, CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
      add_step(row(ROW_CHECKED, CMD_GET, 32'h8000_0000, 32'h0, 1'b1, 32'h7FFF_FFFF));
      // a capacity write empties the store
      add_step(row(ROW_CSR, CMD_GET, 32'h0, 32'd1));
      add_step(row(ROW_CHECKED, CMD_GET, 32'h7FFF_FFFF, 32'h0, 1'b0, READ_MISS));
      add_step(row(ROW_CHECKED, CMD_PUT, 32'd1, 32'd11, 1'b0, PUT_REPLY));
      add_step(row(ROW_CHECKED, CMD_PUT, 32'd2, 32'd22, 1'b0, PUT_REPLY));
      add_step(row(ROW_CHECKED, CMD_GET, 32'd1, 32'h0, 1'b0, READ_MISS));
      add_step(row(ROW_CHECKED, CMD_GET, 32'd2, 32'h0, 1'b1, 32'd22));
      // capacity zero behaves as one
      add_step(row(ROW_CSR, CMD_GET, 32'h0, 32'd0));
      add_step(row(ROW_CHECKED, CMD_PUT, 32'd3, 32'd33, 1'b0, PUT_REPLY));
      add_step(row(ROW_CHECKED, CMD_PUT, 32'd4, 32'd44, 1'b0, PUT_REPLY));
      add_step(row(ROW_CHECKED, CMD_GET, 32'd3, 32'h0, 1'b0, READ_MISS));
      add_step(row(ROW_CHECKED, CMD_GET, 32'd4, 32'h0, 1'b1, 32'd44));
      // a get refreshes 5, so the put of 7 evicts 6
      add_step(row(ROW_CSR, CMD_GET, 32'h0, 32'd2));
      add_step(row(ROW_CHECKED, CMD_PUT, 32'd5, 32'd55, 1'b0, PUT_REPLY));
      add_step(row(ROW_CHECKED, CMD_PUT, 32'd6, 32'd66, 1'b0, PUT_REPLY));
      add_step(row(ROW_CHECKED, CMD_GET, 32'd5, 32'h0, 1'b1, 32'd55));
      add_step(row(ROW_CHECKED, CMD_PUT, 32'd7, 32'd77, 1'b0, PUT_REPLY));
      add_step(row(ROW_CHECKED, CMD_GET, 32'd6, 32'h0, 1'b0, READ_MISS));
      add_step(row(ROW_PREDICTED, CMD_GET, 32'd5, 32'h0));
      add_step(row(ROW_PREDICTED, CMD_GET, 32'd7, 32'h0));
      // oversized capacity saturates
      add_step(row(ROW_CSR, CMD_GET, 32'h0, 32'd31));
      add_step(row(ROW_PREDICTED, CMD_PUT, 32'hFFFF_FFFF, 32'h0));
      add_step(row(ROW_PREDICTED, CMD_GET, 32'hFFFF_FFFF, 32'h0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (steps[i]) begin
         if (steps[i].kind == ROW_CSR) begin
            write_capacity(steps[i].value[4:0]);
         end else begin
            item.command = steps[i].command;
            item.key     = steps[i].key;
            item.value   = steps[i].value;
            issue(item, idle_gap());
            reply = lru_access(item);
            if (steps[i].kind == ROW_CHECKED) begin
               reply.found      = steps[i].found;
               reply.read_value = steps[i].read_value;
            end
            pending_replies.insert(pending_replies.size(), reply);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: cap = 5'd16;
            1: cap = 5'd1;
            2: cap = 5'd3;
            3: cap = 5'd31;
            4: cap = 5'd0;
            5: cap = 5'd8;
            6: cap = 5'($urandom_range(15, 4));
            7: cap = 5'($urandom_range(30, 17));
            default: cap = 5'd2;
         endcase
         write_capacity(cap);
         eff = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : cap;
         // a few more keys than the store holds, so hits and evictions both occur
         pool_size = eff + $urandom_range(5, 1);
         key_pool.delete();
         for (int k = 0; k < pool_size; k++)
            key_pool.insert(key_pool.size(),
                            ($urandom_range(7, 0) == 0) ? edge_word() : $urandom);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            no_idle = (n >= 50 && n < 90);
            item = random_request();
            issue(item, idle_gap());
            reply = lru_access(item);
            pending_replies.insert(pending_replies.size(), reply);
         end
         no_idle = 1'b0;
      end

      start <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
